// ----- rtl/core/qdca_pkg.sv -----
// ----------------------------------------------------------------------------
// qdca_pkg
// Widths, stage map and shared types of the quad diagonal cross area unit.
// ----------------------------------------------------------------------------
package qdca_pkg;

	localparam int CRD_W      = 32;
	localparam int IN_W       = 8 * CRD_W;
	localparam int OUT_W      = 264;
	localparam int DIFF_W     = CRD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int MAG_W      = SUM_W;
	localparam int DELTA_W    = DIFF_W;
	localparam int LO_W       = 33;
	localparam int HI_W       = MAG_W - LO_W;
	localparam int PL_W       = LO_W + DELTA_W;
	localparam int PH_W       = HI_W + DELTA_W;
	localparam int NUMP_W     = MAG_W + DELTA_W;
	localparam int Q_W        = 41;
	localparam int REM_W      = MAG_W;
	localparam int DIV_ST     = Q_W + 1;
	localparam int ST_DIV0    = 6;
	localparam int ST_FIN     = ST_DIV0 + DIV_ST;
	localparam int NST        = ST_FIN + 5;
	localparam int AP_W       = CRD_W + DIFF_W;
	localparam int PAIR_W     = AP_W + 1;
	localparam int ACC_W      = AP_W + 3;
	localparam int AREA_SHIFT = 17;
	localparam int AREA_W     = 64;
	localparam int EXT_W      = AREA_W + AREA_SHIFT;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DUP = 2'd1,
		ST_PAR = 2'd2,
		ST_SAT = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0][CRD_W-1:0] x;
		logic [3:0][CRD_W-1:0] y;
	} pts_t;

	typedef struct packed {
		logic [CRD_W-1:0] w;
		logic [CRD_W-1:0] h;
		logic [CRD_W-1:0] cx;
		logic [CRD_W-1:0] cy;
	} box_t;

	typedef struct packed {
		pts_t p;
		box_t box;
		logic dup;
		logic par;
		logic negx;
		logic negy;
	} side_t;

endpackage

// ----- rtl/core/qdca_div.sv -----
// ----------------------------------------------------------------------------
// qdca_div
// Pipelined restoring divider, a load stage and then one quotient bit per stage, with an early
// flag for quotients of 2^Q_W and above.
// ----------------------------------------------------------------------------
module qdca_div (
	input  logic                              clk,
	input  logic [qdca_pkg::DIV_ST-1:0]       en,
	input  logic [qdca_pkg::NUMP_W-1:0]       num,
	input  logic [qdca_pkg::MAG_W-1:0]        den,
	output logic [qdca_pkg::Q_W-1:0]          quo,
	output logic                              ovf
);
	import qdca_pkg::*;

	logic [REM_W-1:0] rem_s [DIV_ST];
	logic [Q_W-1:0]   quo_s [DIV_ST];
	logic [MAG_W-1:0] den_s [DIV_ST];
	logic             ovf_s [DIV_ST];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= REM_W'(num[NUMP_W-1:Q_W]);
			quo_s[0] <= num[Q_W-1:0];
			den_s[0] <= den;
			ovf_s[0] <= (MAG_W'(num[NUMP_W-1:Q_W]) >= den);
		end
	end

	for (genvar j = 1; j < DIV_ST; j++) begin : g_step
		logic [REM_W:0] trial;
		logic [REM_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[j-1], quo_s[j-1][Q_W-1]};
			diff  = trial - {1'b0, den_s[j-1]};
			ge    = (trial >= {1'b0, den_s[j-1]});
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
				quo_s[j] <= {quo_s[j-1][Q_W-2:0], ge};
				den_s[j] <= den_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
			end
		end
	end

	assign quo = quo_s[DIV_ST-1];
	assign ovf = ovf_s[DIV_ST-1];

endmodule

// ----- rtl/core/quad_diagonal_cross_area_unit.sv -----
// ----------------------------------------------------------------------------
// quad_diagonal_cross_area_unit
// Intersection of line p1p2 with line p3p4, summed triangle areas and
// bounding box of four Q16.16 points.
// ----------------------------------------------------------------------------
//  channel | signals                     | item
//  s       | s_tvalid s_tready s_tdata   | four points in, 256 bits
//  m       | m_tvalid m_tready m_tdata   | status, cross, area, box, 264 bits
//
//  One item per cycle while the output is not stalled.
//  Depth is set by the 42-stage divider, one quotient bit per stage after its load stage.
//  Reset clears the stage valid bits only.
//  Each stage holds only when it is full and the next one holds, so
//  bubbles close up during an output stall.
// ----------------------------------------------------------------------------
module quad_diagonal_cross_area_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y
	input  logic [qdca_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, cross_x, cross_y, area, box_width, box_height,
	// box_center_x, box_center_y, zero fill
	output logic [qdca_pkg::OUT_W-1:0]    m_tdata
);
	import qdca_pkg::*;

	localparam logic signed [Q_W+1:0] V_MAX = (Q_W+2)'(64'sd2147483647);
	localparam logic signed [Q_W+1:0] V_MIN = (Q_W+2)'(-64'sd2147483648);
	localparam logic [Q_W-1:0]        Q_LIM = Q_W'(1) << (Q_W - 1);

	function automatic logic [CRD_W:0] fin_coord(
		input logic [CRD_W-1:0] base,
		input logic [Q_W-1:0]   q,
		input logic             qovf,
		input logic             neg
	);
		logic signed [Q_W+1:0] v;
		logic                  sat;
		logic [CRD_W-1:0]      r;
		v   = neg ? ((Q_W+2)'($signed(base)) - $signed({2'b00, q}))
		          : ((Q_W+2)'($signed(base)) + $signed({2'b00, q}));
		sat = 1'b0;
		r   = v[CRD_W-1:0];
		if (qovf || (q > Q_LIM)) begin
			sat = 1'b1;
			r   = neg ? V_MIN[CRD_W-1:0] : V_MAX[CRD_W-1:0];
		end else if (v > V_MAX) begin
			sat = 1'b1;
			r   = V_MAX[CRD_W-1:0];
		end else if (v < V_MIN) begin
			sat = 1'b1;
			r   = V_MIN[CRD_W-1:0];
		end
		return {sat, r};
	endfunction

	logic [NST-1:0] vld;
	logic [NST-1:0] en;
	logic [NST-1:0] vld_in;

	always_comb begin
		en[NST-1] = !vld[NST-1] || m_tready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign vld_in   = {vld[NST-2:0], s_tvalid};
	assign s_tready = en[0];
	assign m_tvalid = vld[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld[k] <= vld_in[k];
				end
			end
		end
	end

	// stage 1: differences, duplicate check, extremes
	pts_t                   in_pts;
	logic signed [CRD_W-1:0] ix [4];
	logic signed [CRD_W-1:0] iy [4];
	logic                   in_dup;
	logic signed [CRD_W-1:0] mnx, mxx, mny, mxy;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			in_pts.x[i] = s_tdata[2*CRD_W*i +: CRD_W];
			in_pts.y[i] = s_tdata[2*CRD_W*i+CRD_W +: CRD_W];
			ix[i]       = $signed(in_pts.x[i]);
			iy[i]       = $signed(in_pts.y[i]);
		end
		in_dup = 1'b0;
		for (int i = 0; i < 4; i++) begin
			for (int j = i + 1; j < 4; j++) begin
				if ((ix[i] == ix[j]) && (iy[i] == iy[j])) begin
					in_dup = 1'b1;
				end
			end
		end
		mnx = ix[0];
		mxx = ix[0];
		mny = iy[0];
		mxy = iy[0];
		for (int i = 1; i < 4; i++) begin
			if (ix[i] < mnx) mnx = ix[i];
			if (ix[i] > mxx) mxx = ix[i];
			if (iy[i] < mny) mny = iy[i];
			if (iy[i] > mxy) mxy = iy[i];
		end
	end

	pts_t                     pts_s1;
	logic                     dup_s1;
	logic signed [DIFF_W-1:0] a_s1, b_s1, dx31_s1, dy31_s1, dx34_s1, dy34_s1;
	logic signed [DIFF_W-1:0] ddx_s1, ddy_s1;
	logic signed [CRD_W-1:0]  mnx_s1, mxx_s1, mny_s1, mxy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pts_s1  <= in_pts;
			dup_s1  <= in_dup;
			a_s1    <= DIFF_W'(iy[0]) - DIFF_W'(iy[1]);
			b_s1    <= DIFF_W'(ix[1]) - DIFF_W'(ix[0]);
			dx31_s1 <= DIFF_W'(ix[2]) - DIFF_W'(ix[0]);
			dy31_s1 <= DIFF_W'(iy[2]) - DIFF_W'(iy[0]);
			dx34_s1 <= DIFF_W'(ix[2]) - DIFF_W'(ix[3]);
			dy34_s1 <= DIFF_W'(iy[2]) - DIFF_W'(iy[3]);
			ddx_s1  <= DIFF_W'(ix[3]) - DIFF_W'(ix[2]);
			ddy_s1  <= DIFF_W'(iy[3]) - DIFF_W'(iy[2]);
			mnx_s1  <= mnx;
			mxx_s1  <= mxx;
			mny_s1  <= mny;
			mxy_s1  <= mxy;
		end
	end

	// stage 2: cross products, box
	pts_t                     pts_s2;
	logic                     dup_s2;
	box_t                     box_s2;
	logic signed [PROD_W-1:0] pn1_s2, pn2_s2, pd1_s2, pd2_s2;
	logic signed [DIFF_W-1:0] ddx_s2, ddy_s2;
	logic signed [CRD_W:0]    sumx, sumy;

	always_comb begin
		sumx = (CRD_W+1)'(mnx_s1) + (CRD_W+1)'(mxx_s1);
		sumy = (CRD_W+1)'(mny_s1) + (CRD_W+1)'(mxy_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pts_s2     <= pts_s1;
			dup_s2     <= dup_s1;
			pn1_s2     <= dx31_s1 * a_s1;
			pn2_s2     <= dy31_s1 * b_s1;
			pd1_s2     <= dx34_s1 * a_s1;
			pd2_s2     <= dy34_s1 * b_s1;
			ddx_s2     <= ddx_s1;
			ddy_s2     <= ddy_s1;
			box_s2.w   <= mxx_s1 - mnx_s1;
			box_s2.h   <= mxy_s1 - mny_s1;
			box_s2.cx  <= sumx[CRD_W:1];
			box_s2.cy  <= sumy[CRD_W:1];
		end
	end

	// stage 3: numerator, denominator
	pts_t                     pts_s3;
	logic                     dup_s3;
	box_t                     box_s3;
	logic signed [SUM_W-1:0]  num_s3, den_s3;
	logic signed [DIFF_W-1:0] ddx_s3, ddy_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pts_s3 <= pts_s2;
			dup_s3 <= dup_s2;
			box_s3 <= box_s2;
			num_s3 <= SUM_W'(pn1_s2) + SUM_W'(pn2_s2);
			den_s3 <= SUM_W'(pd1_s2) + SUM_W'(pd2_s2);
			ddx_s3 <= ddx_s2;
			ddy_s3 <= ddy_s2;
		end
	end

	// stage 4: signs and magnitudes
	side_t              side_s4;
	logic [MAG_W-1:0]   mnum_s4, mden_s4;
	logic [DELTA_W-1:0] mdx_s4, mdy_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			side_s4.p    <= pts_s3;
			side_s4.box  <= box_s3;
			side_s4.dup  <= dup_s3;
			side_s4.par  <= (den_s3 == '0);
			side_s4.negx <= ddx_s3[DIFF_W-1] ^ num_s3[SUM_W-1] ^ den_s3[SUM_W-1];
			side_s4.negy <= ddy_s3[DIFF_W-1] ^ num_s3[SUM_W-1] ^ den_s3[SUM_W-1];
			mnum_s4      <= num_s3[SUM_W-1] ? MAG_W'(-num_s3) : MAG_W'(num_s3);
			mden_s4      <= den_s3[SUM_W-1] ? MAG_W'(-den_s3) : MAG_W'(den_s3);
			mdx_s4       <= ddx_s3[DIFF_W-1] ? DELTA_W'(-ddx_s3) : DELTA_W'(ddx_s3);
			mdy_s4       <= ddy_s3[DIFF_W-1] ? DELTA_W'(-ddy_s3) : DELTA_W'(ddy_s3);
		end
	end

	// stage 5: partial products of |num| * |delta|
	side_t            side_s5;
	logic [MAG_W-1:0] mden_s5;
	logic [PL_W-1:0]  plx_s5, ply_s5;
	logic [PH_W-1:0]  phx_s5, phy_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			side_s5 <= side_s4;
			mden_s5 <= mden_s4;
			plx_s5  <= mnum_s4[LO_W-1:0] * mdx_s4;
			phx_s5  <= mnum_s4[MAG_W-1:LO_W] * mdx_s4;
			ply_s5  <= mnum_s4[LO_W-1:0] * mdy_s4;
			phy_s5  <= mnum_s4[MAG_W-1:LO_W] * mdy_s4;
		end
	end

	// stage 6: full dividends
	side_t             side_s6;
	logic [MAG_W-1:0]  mden_s6;
	logic [NUMP_W-1:0] prx_s6, pry_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			side_s6 <= side_s5;
			mden_s6 <= mden_s5;
			prx_s6  <= NUMP_W'(plx_s5) + (NUMP_W'(phx_s5) << LO_W);
			pry_s6  <= NUMP_W'(ply_s5) + (NUMP_W'(phy_s5) << LO_W);
		end
	end

	// divider stages
	logic [Q_W-1:0] quox, quoy;
	logic           ovfx, ovfy;
	side_t          side_d [DIV_ST];

	qdca_div u_divx (
		.clk (clk),
		.en  (en[ST_FIN-1:ST_DIV0]),
		.num (prx_s6),
		.den (mden_s6),
		.quo (quox),
		.ovf (ovfx)
	);

	qdca_div u_divy (
		.clk (clk),
		.en  (en[ST_FIN-1:ST_DIV0]),
		.num (pry_s6),
		.den (mden_s6),
		.quo (quoy),
		.ovf (ovfy)
	);

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_ST; j++) begin
			if (en[ST_DIV0+j]) begin
				side_d[j] <= (j == 0) ? side_s6 : side_d[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// stage 49: crossing point and status
	side_t          sd;
	logic [CRD_W:0] fx, fy;
	logic           nz;

	always_comb begin
		sd = side_d[DIV_ST-1];
		fx = fin_coord(sd.p.x[2], quox, ovfx, sd.negx);
		fy = fin_coord(sd.p.y[2], quoy, ovfy, sd.negy);
		nz = sd.dup || sd.par;
	end

	pts_t             pts_s49;
	box_t             box_s49;
	status_t          st_s49;
	logic [CRD_W-1:0] cx_s49, cy_s49;

	always_ff @(posedge clk) begin
		if (en[ST_FIN]) begin
			pts_s49 <= sd.p;
			box_s49 <= sd.box;
			cx_s49  <= nz ? '0 : fx[CRD_W-1:0];
			cy_s49  <= nz ? '0 : fy[CRD_W-1:0];
			if (sd.dup) begin
				st_s49 <= ST_DUP;
			end else if (sd.par) begin
				st_s49 <= ST_PAR;
			end else if (fx[CRD_W] || fy[CRD_W]) begin
				st_s49 <= ST_SAT;
			end else begin
				st_s49 <= ST_OK;
			end
		end
	end

	// stage 50: area differences
	logic signed [CRD_W-1:0]  c49y, y49 [4];
	pts_t                     pts_s50;
	box_t                     box_s50;
	status_t                  st_s50;
	logic [CRD_W-1:0]         cx_s50, cy_s50;
	logic signed [DIFF_W-1:0] d_s50 [6];

	always_comb begin
		c49y = $signed(cy_s49);
		for (int i = 0; i < 4; i++) begin
			y49[i] = $signed(pts_s49.y[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_FIN+1]) begin
			pts_s50  <= pts_s49;
			box_s50  <= box_s49;
			st_s50   <= st_s49;
			cx_s50   <= cx_s49;
			cy_s50   <= cy_s49;
			d_s50[0] <= DIFF_W'(y49[3]) - DIFF_W'(c49y);
			d_s50[1] <= DIFF_W'(c49y) - DIFF_W'(y49[0]);
			d_s50[2] <= DIFF_W'(y49[0]) - DIFF_W'(y49[3]);
			d_s50[3] <= DIFF_W'(y49[2]) - DIFF_W'(c49y);
			d_s50[4] <= DIFF_W'(c49y) - DIFF_W'(y49[1]);
			d_s50[5] <= DIFF_W'(y49[1]) - DIFF_W'(y49[2]);
		end
	end

	// stage 51: area products
	box_t                   box_s51;
	status_t                st_s51;
	logic [CRD_W-1:0]       cx_s51, cy_s51;
	logic signed [AP_W-1:0] m_s51 [6];

	always_ff @(posedge clk) begin
		if (en[ST_FIN+2]) begin
			box_s51  <= box_s50;
			st_s51   <= st_s50;
			cx_s51   <= cx_s50;
			cy_s51   <= cy_s50;
			m_s51[0] <= $signed(pts_s50.x[0]) * d_s50[0];
			m_s51[1] <= $signed(pts_s50.x[3]) * d_s50[1];
			m_s51[2] <= $signed(cx_s50) * d_s50[2];
			m_s51[3] <= $signed(pts_s50.x[1]) * d_s50[3];
			m_s51[4] <= $signed(pts_s50.x[2]) * d_s50[4];
			m_s51[5] <= $signed(cx_s50) * d_s50[5];
		end
	end

	// stage 52: pair sums
	box_t                     box_s52;
	status_t                  st_s52;
	logic [CRD_W-1:0]         cx_s52, cy_s52;
	logic signed [PAIR_W-1:0] pr_s52 [3];

	always_ff @(posedge clk) begin
		if (en[ST_FIN+3]) begin
			box_s52 <= box_s51;
			st_s52  <= st_s51;
			cx_s52  <= cx_s51;
			cy_s52  <= cy_s51;
			for (int i = 0; i < 3; i++) begin
				pr_s52[i] <= PAIR_W'(m_s51[2*i]) + PAIR_W'(m_s51[2*i+1]);
			end
		end
	end

	// stage 53: output register
	logic signed [ACC_W-1:0] acc;
	logic signed [EXT_W-1:0] acc_ext;
	box_t                    box_s53;
	status_t                 st_s53;
	logic [CRD_W-1:0]        cx_s53, cy_s53;
	logic [AREA_W-1:0]       area_s53;

	always_comb begin
		acc     = ACC_W'(pr_s52[0]) + ACC_W'(pr_s52[1]) + ACC_W'(pr_s52[2]);
		acc_ext = EXT_W'(acc);
	end

	always_ff @(posedge clk) begin
		if (en[ST_FIN+4]) begin
			box_s53  <= box_s52;
			st_s53   <= st_s52;
			cx_s53   <= cx_s52;
			cy_s53   <= cy_s52;
			area_s53 <= ((st_s52 == ST_DUP) || (st_s52 == ST_PAR)) ? '0
			            : acc_ext[EXT_W-1:AREA_SHIFT];
		end
	end

	assign m_tdata = {(OUT_W - 258)'(0), box_s53.cy, box_s53.cx, box_s53.h, box_s53.w,
	                  area_s53, cy_s53, cx_s53, st_s53};

	ap_dup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (st_s53 == ST_DUP)) |->
		((cx_s53 == '0) && (cy_s53 == '0) && (area_s53 == '0)))
		else $error("duplicate item carries nonzero crossing data");

	ap_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (st_s53 == ST_PAR)) |->
		((cx_s53 == '0) && (cy_s53 == '0) && (area_s53 == '0)))
		else $error("parallel item carries nonzero crossing data");

	ap_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && (&vld)))
		else $error("input held back while the pipeline has room");

endmodule
